@@ sv/acl_pkg.sv @@
// ----------------------------------------------------------------------------
// acl_pkg: shared types and constants
// line summary record, status codes and character constants
// ----------------------------------------------------------------------------
package acl_pkg;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_T     = 8'h54;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_EQ    = 8'h3D;
  localparam logic [7:0] CHAR_QUERY = 8'h3F;

  localparam logic [7:0] MAX_LENGTH_RESET = 8'd100;
  localparam logic [7:0] NAME_OFFSET      = 8'd3;
  localparam logic [8:0] BARE_LENGTH      = 9'd2;

  localparam logic [3:0] ST_TOO_LONG    = 4'd0;
  localparam logic [3:0] ST_NO_AT       = 4'd1;
  localparam logic [3:0] ST_NO_PLUS     = 4'd2;
  localparam logic [3:0] ST_EMPTY_QUERY = 4'd3;
  localparam logic [3:0] ST_EMPTY_VALUE = 4'd4;
  localparam logic [3:0] ST_BARE        = 4'd5;
  localparam logic [3:0] ST_PLAIN       = 4'd6;
  localparam logic [3:0] ST_SET         = 4'd7;
  localparam logic [3:0] ST_QUERY       = 4'd8;

  typedef struct packed {
    logic [8:0] len;
    logic       prefix_ok;
    logic       plus_ok;
    logic       eq_seen;
    logic [7:0] eq_off;
    logic       q_seen;
    logic [7:0] q_off;
  } line_sum_t;

endpackage

@@ sv/acl_front.sv @@
// ----------------------------------------------------------------------------
// acl_front: per-character scanner
// tracks prefix, plus, first equals and first query of the current line and
// emits a line summary on the terminator
// ----------------------------------------------------------------------------
module acl_front import acl_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      take,
  input  logic [7:0] ch,
  output logic      push,
  output line_sum_t push_data
);

  logic [8:0] char_count;
  logic       prefix_ok;
  logic       plus_ok;
  logic       eq_seen;
  logic [7:0] eq_off;
  logic       q_seen;
  logic [7:0] q_off;

  logic [7:0] p;
  logic       in_range;
  logic       is_term;

  assign p        = char_count[7:0];
  assign in_range = ~char_count[8];
  assign is_term  = (ch == CHAR_NUL);

  assign push = take & is_term;
  always_comb begin
    push_data.len       = char_count;
    push_data.prefix_ok = prefix_ok;
    push_data.plus_ok   = plus_ok;
    push_data.eq_seen   = eq_seen;
    push_data.eq_off    = eq_off;
    push_data.q_seen    = q_seen;
    push_data.q_off     = q_off;
  end

  always_ff @(posedge clk) begin
    if (rst || push) begin
      char_count <= '0;
      prefix_ok  <= 1'b1;
      plus_ok    <= 1'b0;
      eq_seen    <= 1'b0;
      eq_off     <= '0;
      q_seen     <= 1'b0;
      q_off      <= '0;
    end else if (take) begin
      if (char_count == 9'd0 && ch != CHAR_A) prefix_ok <= 1'b0;
      if (char_count == 9'd1 && ch != CHAR_T) prefix_ok <= 1'b0;
      if (char_count == 9'd2) plus_ok <= (ch == CHAR_PLUS);
      if (in_range) begin
        if (ch == CHAR_EQ && !eq_seen) begin
          eq_seen <= 1'b1;
          eq_off  <= p;
        end
        if (ch == CHAR_QUERY && !q_seen) begin
          q_seen <= 1'b1;
          q_off  <= p;
        end
        char_count <= char_count + 9'd1;
      end
    end
  end

endmodule

@@ sv/acl_fifo.sv @@
// ----------------------------------------------------------------------------
// acl_fifo: line summary queue
// small register queue between scanner and classifier
// ----------------------------------------------------------------------------
module acl_fifo import acl_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  line_sum_t push_data,
  output logic      full,
  input  logic      pop,
  output logic      not_empty,
  output line_sum_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  line_sum_t     entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full      = (count == FULL_COUNT);
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PW'(1);
      if (pop)  rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PW'(1);
      if (push && !pop) count <= count + CW'(1);
      else if (pop && !push) count <= count - CW'(1);
    end
  end

endmodule

@@ sv/acl_back.sv @@
// ----------------------------------------------------------------------------
// acl_back: line classifier
// holds max_length, classifies a queued summary into the output register
// ----------------------------------------------------------------------------
module acl_back import acl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data,
  input  logic       avail,
  input  line_sum_t  head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] status,
  output logic [7:0] token_pos,
  output logic [7:0] value_pos,
  output logic [8:0] line_length
);

  logic [7:0] max_length;
  logic [3:0] st_next;
  logic [7:0] tok_next;
  logic [7:0] val_next;
  logic [8:0] eq_end;
  logic       load;

  assign load   = ~out_valid | ~out_stall;
  assign pop    = avail & load;
  assign eq_end = {1'b0, head.eq_off} + 9'd1;

  always_comb begin
    st_next  = ST_PLAIN;
    tok_next = '0;
    val_next = '0;
    if (head.len > {1'b0, max_length}) begin
      st_next = ST_TOO_LONG;
    end else if (head.len < BARE_LENGTH || !head.prefix_ok) begin
      st_next = ST_NO_AT;
    end else if (head.len == BARE_LENGTH) begin
      st_next = ST_BARE;
    end else if (!head.plus_ok) begin
      st_next = ST_NO_PLUS;
    end else if (head.eq_seen) begin
      if (eq_end >= head.len) begin
        st_next = ST_EMPTY_VALUE;
      end else begin
        st_next  = ST_SET;
        tok_next = head.eq_off;
        val_next = eq_end[7:0];
      end
    end else if (head.q_seen) begin
      if (head.q_off > NAME_OFFSET) begin
        st_next  = ST_QUERY;
        tok_next = head.q_off;
      end else begin
        st_next = ST_EMPTY_QUERY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= MAX_LENGTH_RESET;
    end else if (cfg_we) begin
      max_length <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= avail;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      status      <= st_next;
      token_pos   <= tok_next;
      value_pos   <= val_next;
      line_length <= head.len;
    end
  end

endmodule

@@ sv/at_command_line_classifier_top.sv @@
// ----------------------------------------------------------------------------
// at_command_line_classifier_top: AT command line classifier
// scans a line one byte per beat and classifies it on the zero terminator
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------
//  in      | in_valid / in_stall  | ch
//  out     | out_valid / out_stall| status, token_pos, value_pos, line_length
//  cfg     | cfg_valid / cfg_ready| cfg_data (max_length)
//
//  one byte per cycle while in_stall is low; a terminator's summary is queued, then registered at the output
//  the scanner counts and marks tokens, the classifier decides from the summary
//  in_stall is high only while the summary queue is full
//  rst clears line state, queue and output; max_length returns to 100
// ----------------------------------------------------------------------------
module at_command_line_classifier_top import acl_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] ch,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] status,
  output logic [7:0] token_pos,
  output logic [7:0] value_pos,
  output logic [8:0] line_length,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  logic      take;
  logic      push;
  line_sum_t push_data;
  logic      full;
  logic      pop;
  logic      avail;
  line_sum_t head;

  assign in_stall  = full;
  assign take      = in_valid & ~full;
  assign cfg_ready = 1'b1;

  acl_front u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .ch        (ch),
    .push      (push),
    .push_data (push_data)
  );

  acl_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .not_empty (avail),
    .head      (head)
  );

  acl_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_valid & cfg_ready),
    .cfg_data    (cfg_data),
    .avail       (avail),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .token_pos   (token_pos),
    .value_pos   (value_pos),
    .line_length (line_length)
  );

endmodule

@@ test/tb_at_command_line_classifier_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_at_command_line_classifier_top: regression bench for the AT line classifier
// feeds command lines one byte per beat, first from a short table of known
// lines and then as random well-formed, broken and noisy lines under several
// max_length settings; the table or a local line scanner gives each line's class and
// every output beat is compared with the oldest prediction
// ----------------------------------------------------------------------------
module tb_at_command_line_classifier_top;
  import acl_pkg::*;

  typedef struct packed {
    logic [3:0] status;
    logic [7:0] token_pos;
    logic [7:0] value_pos;
    logic [8:0] line_length;
  } line_verdict_t;

  localparam int N_ROWS    = 23;
  localparam int ITEM_GOAL = 1700;
  localparam int LONG_HOLD = 60;
  localparam int SETTLE    = 4;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] ch = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [3:0] status;
  logic [7:0] token_pos;
  logic [7:0] value_pos;
  logic [8:0] line_length;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = 8'h00;

  // scanner copy and line limit
  logic [7:0] max_len = MAX_LENGTH_RESET;
  logic [8:0] seen_len = '0;
  logic       prefix_good = 1'b1;
  logic       plus_good = 1'b0;
  logic       eq_seen = 1'b0;
  logic [7:0] eq_at = '0;
  logic       q_seen = 1'b0;
  logic [7:0] q_at = '0;

  line_verdict_t verdict_q[$];
  int            fail_count = 0;
  int            sent_items = 0;
  int            tx_idle_pct = 0;
  int            rx_idle_pct = 0;
  bit            rx_hold_req = 1'b0;

  // directed lines: head text, filler count and byte, limit to set first
  string         row_head[N_ROWS] = '{"", "A", "AT", "at", "AT+", "ATX", "AT+CWMODE?",
                                      "AT+?", "AT+CWMODE=", "AT+CWMODE=1", "AT+=5",
                                      "AT+X?=1?", "AT+A=", "?T+A", "AT=", "AT+", "AT+",
                                      "AT+", "AT+", "AT+", "AT", "AT+", ""};
  int            row_pad[N_ROWS]  = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 3, 0, 0,
                                      97, 98, 252, 253, 400, 0, 0, 0};
  logic [7:0]    row_fill[N_ROWS] = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00,
                                      8'h00, 8'h41, 8'h41, 8'h42, 8'h42, 8'h3D, 8'h00,
                                      8'h00, 8'h00};
  int            row_max[N_ROWS]  = '{-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1,
                                      -1, -1, -1, -1, -1, 255, -1, -1, 2, -1, -1};
  bit            row_typed[N_ROWS] = '{1, 1, 1, 1, 0, 1, 0, 1, 1, 0, 0, 0, 0, 1, 1,
                                       0, 1, 0, 1, 1, 1, 1, 1};
  line_verdict_t row_want[N_ROWS] = '{
    {ST_NO_AT, 8'd0, 8'd0, 9'd0},       {ST_NO_AT, 8'd0, 8'd0, 9'd1},
    {ST_BARE, 8'd0, 8'd0, 9'd2},        {ST_NO_AT, 8'd0, 8'd0, 9'd2},
    '0,                                 {ST_NO_PLUS, 8'd0, 8'd0, 9'd3},
    '0,                                 {ST_EMPTY_QUERY, 8'd0, 8'd0, 9'd4},
    {ST_EMPTY_VALUE, 8'd0, 8'd0, 9'd10}, '0,
    '0,                                 '0,
    '0,                                 {ST_NO_AT, 8'd0, 8'd0, 9'd4},
    {ST_NO_PLUS, 8'd0, 8'd0, 9'd3},     '0,
    {ST_TOO_LONG, 8'd0, 8'd0, 9'd101},  '0,
    {ST_TOO_LONG, 8'd0, 8'd0, 9'd256},  {ST_TOO_LONG, 8'd0, 8'd0, 9'd256},
    {ST_BARE, 8'd0, 8'd0, 9'd2},        {ST_TOO_LONG, 8'd0, 8'd0, 9'd3},
    {ST_NO_AT, 8'd0, 8'd0, 9'd0}};

  at_command_line_classifier_top dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .ch          (ch),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .token_pos   (token_pos),
    .value_pos   (value_pos),
    .line_length (line_length),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void scan_char(input logic [7:0] c, output bit line_done,
                                    output line_verdict_t v);
    logic [8:0] p;
    p = seen_len;
    line_done = 1'b0;
    v = '0;
    if (c != CHAR_NUL) begin
      if (p == 9'd0 && c != CHAR_A) prefix_good = 1'b0;
      if (p == 9'd1 && c != CHAR_T) prefix_good = 1'b0;
      if (p == 9'd2) plus_good = (c == CHAR_PLUS);
      // counter holds at 256, later bytes not examined
      if (!p[8]) begin
        if (c == CHAR_EQ && !eq_seen) begin
          eq_seen = 1'b1;
          eq_at = p[7:0];
        end
        if (c == CHAR_QUERY && !q_seen) begin
          q_seen = 1'b1;
          q_at = p[7:0];
        end
        seen_len = p + 9'd1;
      end
    end else begin
      line_done = 1'b1;
      v.line_length = p;
      if (p > {1'b0, max_len}) begin
        v.status = ST_TOO_LONG;
      end else if (p < BARE_LENGTH || !prefix_good) begin
        v.status = ST_NO_AT;
      end else if (p == BARE_LENGTH) begin
        v.status = ST_BARE;
      end else if (!plus_good) begin
        v.status = ST_NO_PLUS;
      end else if (eq_seen) begin
        if ({1'b0, eq_at} + 9'd1 >= p) begin
          v.status = ST_EMPTY_VALUE;
        end else begin
          v.status = ST_SET;
          v.token_pos = eq_at;
          v.value_pos = eq_at + 8'd1;
        end
      end else if (q_seen) begin
        if (q_at > NAME_OFFSET) begin
          v.status = ST_QUERY;
          v.token_pos = q_at;
        end else begin
          v.status = ST_EMPTY_QUERY;
        end
      end else begin
        v.status = ST_PLAIN;
      end
      seen_len = '0;
      prefix_good = 1'b1;
      plus_good = 1'b0;
      eq_seen = 1'b0;
      eq_at = '0;
      q_seen = 1'b0;
      q_at = '0;
    end
  endfunction

  function automatic logic [7:0] any_char();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return CHAR_EQ;
    if (r == 1) return CHAR_QUERY;
    return 8'($urandom_range(1, 255));
  endfunction

  task automatic push_char(input logic [7:0] c, output bit line_done,
                           output line_verdict_t v);
    if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    ch <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_items++;
    scan_char(c, line_done, v);
  endtask

  task automatic send_line(input logic [7:0] body[$], input bit typed,
                           input line_verdict_t want);
    bit            done;
    line_verdict_t v;
    body.push_back(CHAR_NUL);
    foreach (body[k]) begin
      push_char(body[k], done, v);
      if (done) verdict_q.push_back(typed ? want : v);
    end
  endtask

  // register writes only once the line results have drained
  task automatic set_max_len(input logic [7:0] value);
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    max_len = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic random_line();
    logic [7:0]    b[$];
    int            kind;
    int            n;
    line_verdict_t none;
    none = '0;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      b = {CHAR_A, CHAR_T, CHAR_PLUS};
      n = $urandom_range(0, 6);
      repeat (n) b.push_back(CHAR_A + 8'($urandom_range(0, 25)));
      case ($urandom_range(0, 3))
        1: b.push_back(CHAR_QUERY);
        2, 3: begin
          b.push_back(CHAR_EQ);
          n = $urandom_range(0, 6);
          repeat (n) b.push_back(any_char());
        end
        default: ;
      endcase
    end else if (kind < 82) begin
      b = {CHAR_A, CHAR_T};
      n = $urandom_range(0, 4);
      repeat (n) b.push_back(any_char());
      if ($urandom_range(0, 1) == 1) b[$urandom_range(0, 1)] = any_char();
    end else if (kind < 97) begin
      n = $urandom_range(0, 10);
      repeat (n) b.push_back(any_char());
    end else begin
      // around the length limit
      b = {CHAR_A, CHAR_T, CHAR_PLUS};
      n = int'(max_len) - 6 + $urandom_range(0, 8);
      if (n < 0) n = 0;
      repeat (n) b.push_back(any_char());
    end
    send_line(b, 1'b0, none);
  endtask

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    line_verdict_t want;
    if (!rst && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual status %0d length %0d",
                 $time, status, line_length);
        fail_count++;
      end else begin
        want = verdict_q.pop_front();
        check_field("status", want.status, status);
        check_field("token_pos", want.token_pos, token_pos);
        check_field("value_pos", want.value_pos, value_pos);
        check_field("line_length", want.line_length, line_length);
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #1_000_000;
    $display("at_command_line_classifier_top regression: fail");
    $finish;
  end

  initial begin
    logic [7:0]    body[$];
    logic [7:0]    bare[$];
    line_verdict_t none;
    int            phase;
    int            phase_start;
    bit            quiet;
    none = '0;
    bare = {CHAR_A, CHAR_T};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // known lines, reset limit first
    tx_idle_pct = 20;
    rx_idle_pct = 20;
    for (int i = 0; i < N_ROWS; i++) begin
      if (row_max[i] >= 0) set_max_len(8'(row_max[i]));
      body = {};
      for (int k = 0; k < row_head[i].len(); k++) body.push_back(row_head[i][k]);
      repeat (row_pad[i]) body.push_back(row_fill[i]);
      send_line(body, row_typed[i], row_want[i]);
    end

    // random lines over several limits
    phase = 0;
    quiet = 1'b0;
    while (sent_items < ITEM_GOAL) begin
      quiet = (sent_items > ITEM_GOAL - 250);
      case (phase)
        0: set_max_len(8'd255);
        1: set_max_len(8'd2);
        2: set_max_len(MAX_LENGTH_RESET);
        default: set_max_len(8'($urandom_range(8, 255)));
      endcase
      if (quiet) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else begin
        tx_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
        rx_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
      end
      if (phase == 1) begin
        // receiver holds off while short lines keep coming
        rx_hold_req = 1'b1;
        repeat (16) send_line(bare, 1'b0, none);
      end
      phase_start = sent_items;
      while (sent_items - phase_start < 100 && sent_items < ITEM_GOAL) random_line();
      phase++;
    end

    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("at_command_line_classifier_top regression: pass");
    end else begin
      $display("at_command_line_classifier_top regression: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/acl_pkg.sv
sv/acl_front.sv
sv/acl_fifo.sv
sv/acl_back.sv
sv/at_command_line_classifier_top.sv
test/tb_at_command_line_classifier_top.sv
